>>> src/ppmcm_pkg.sv
// ----------------------------------------------------------------------------
// ppmcm_pkg
// Shared constants, types and states for the pulse period color mapper.
// ----------------------------------------------------------------------------
package ppmcm_pkg;

    localparam int EDGES_PER_BURST = 5;
    localparam int NUM_DIFF        = EDGES_PER_BURST - 1;
    localparam int COUNT_W         = $clog2(EDGES_PER_BURST);
    localparam int DIFF_IW         = $clog2(NUM_DIFF);
    localparam int SCORE_W         = $clog2(NUM_DIFF + 1);

    localparam int TIME_W   = 32;
    localparam int PERIOD_W = 31;
    localparam int VALUE_W  = 8;
    localparam int CHAN_W   = 2;

    localparam int IN_DATA_W  = 32;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 40;
    localparam int OUT_USER_W = 2;

    localparam int CFG_IDX_W   = 3;
    localparam int LIMIT_W     = 31;
    localparam int SLOW_RESET  = 1000;

    // 0.2 percent window: |dx - di| * 500 <= dx
    localparam int WINDOW_SCALE = 500;
    localparam int ERR_W        = PERIOD_W + $clog2(WINDOW_SCALE);

    // intensity divider: quotient of (slow - p) * 255 / (slow - fast)
    localparam int DIV_STEPS = VALUE_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);
    localparam int REM_W     = PERIOD_W + VALUE_W;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CHAN_W-1:0] CH_RED   = 2'd0;
    localparam logic [CHAN_W-1:0] CH_GREEN = 2'd1;
    localparam logic [CHAN_W-1:0] CH_BLUE  = 2'd2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RED_FAST,
        REG_RED_SLOW,
        REG_GREEN_FAST,
        REG_GREEN_SLOW,
        REG_BLUE_FAST,
        REG_BLUE_SLOW
    } cfg_reg_t;

    typedef struct packed {
        logic [LIMIT_W-1:0] red_fast;
        logic [LIMIT_W-1:0] red_slow;
        logic [LIMIT_W-1:0] green_fast;
        logic [LIMIT_W-1:0] green_slow;
        logic [LIMIT_W-1:0] blue_fast;
        logic [LIMIT_W-1:0] blue_slow;
    } limits_t;

    // one finished burst handed from front to back
    typedef struct packed {
        logic [NUM_DIFF-1:0][PERIOD_W-1:0] diff;
        logic [CHAN_W-1:0]                 channel;
    } burst_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_SCORE,
        BK_CLAMP,
        BK_PREP,
        BK_DIVIDE,
        BK_DONE
    } bk_state_t;

endpackage

>>> src/ppmcm_front.sv
// ----------------------------------------------------------------------------
// ppmcm_front
// Takes edge timestamps, forms the period differences of a burst and hands
// the finished burst to the queue.
// ----------------------------------------------------------------------------
module ppmcm_front (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [ppmcm_pkg::IN_DATA_W-1:0]     s_tdata,   // edge_time
    input  logic [ppmcm_pkg::IN_USER_W-1:0]     s_tuser,   // channel
    input  logic                                q_full,
    output logic                                push,
    output ppmcm_pkg::burst_t                   push_data
);

    logic [ppmcm_pkg::COUNT_W-1:0]                         edge_count_reg;
    logic [ppmcm_pkg::COUNT_W-1:0]                         edge_count_next;
    logic [ppmcm_pkg::TIME_W-1:0]                          prev_reg;
    logic [ppmcm_pkg::TIME_W-1:0]                          prev_next;
    logic [ppmcm_pkg::NUM_DIFF-1:0][ppmcm_pkg::PERIOD_W-1:0] store_reg;
    logic [ppmcm_pkg::NUM_DIFF-1:0][ppmcm_pkg::PERIOD_W-1:0] store_next;
    logic [ppmcm_pkg::NUM_DIFF-1:0][ppmcm_pkg::PERIOD_W-1:0] store_upd;
    logic [ppmcm_pkg::TIME_W-1:0]                          diff;
    logic                                                  negative;
    logic                                                  last_edge;
    logic                                                  accept;

    assign diff      = s_tdata - prev_reg;
    assign negative  = diff[ppmcm_pkg::TIME_W-1];
    assign last_edge = (edge_count_reg == ppmcm_pkg::COUNT_W'(ppmcm_pkg::EDGES_PER_BURST - 1));
    assign s_tready  = !last_edge || !q_full;
    assign accept    = s_tvalid && s_tready;
    assign push      = accept && last_edge;

    // first edge only sets the previous time, edge k lands in entry k-1
    always_comb
    begin
        for (int j = 0; j < ppmcm_pkg::NUM_DIFF; j++)
        begin
            if (!negative && (edge_count_reg == ppmcm_pkg::COUNT_W'(j + 1)))
            begin
                store_upd[j] = diff[ppmcm_pkg::PERIOD_W-1:0];
            end
            else
            begin
                store_upd[j] = store_reg[j];
            end
        end
    end

    always_comb
    begin
        push_data.diff = store_upd;
        if (s_tuser > ppmcm_pkg::CH_BLUE)
        begin
            push_data.channel = ppmcm_pkg::CH_BLUE;
        end
        else
        begin
            push_data.channel = s_tuser;
        end
    end

    always_comb
    begin
        edge_count_next = edge_count_reg;
        prev_next       = prev_reg;
        store_next      = store_reg;
        if (accept)
        begin
            if (last_edge)
            begin
                edge_count_next = '0;
                prev_next       = '0;
                store_next      = '0;
            end
            else
            begin
                edge_count_next = edge_count_reg + 1'b1;
                store_next      = store_upd;
                if (!negative)
                begin
                    prev_next = s_tdata;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            edge_count_reg <= '0;
            prev_reg       <= '0;
            store_reg      <= '0;
        end
        else
        begin
            edge_count_reg <= edge_count_next;
            prev_reg       <= prev_next;
            store_reg      <= store_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        edge_count_reg <= ppmcm_pkg::COUNT_W'(ppmcm_pkg::EDGES_PER_BURST - 1))
        else $error("edge count ran past the burst length");
`endif

endmodule

>>> src/ppmcm_queue.sv
// ----------------------------------------------------------------------------
// ppmcm_queue
// Short queue of finished bursts between the front and the back end.
// ----------------------------------------------------------------------------
module ppmcm_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  ppmcm_pkg::burst_t push_data,
    output logic              full,
    input  logic              pop,
    output logic              pop_valid,
    output ppmcm_pkg::burst_t pop_data
);

    ppmcm_pkg::burst_t               entry_reg [ppmcm_pkg::QUEUE_DEPTH];
    logic [ppmcm_pkg::QPTR_W-1:0]    wr_ptr_reg;
    logic [ppmcm_pkg::QPTR_W-1:0]    wr_ptr_next;
    logic [ppmcm_pkg::QPTR_W-1:0]    rd_ptr_reg;
    logic [ppmcm_pkg::QPTR_W-1:0]    rd_ptr_next;
    logic [ppmcm_pkg::QCNT_W-1:0]    count_reg;
    logic [ppmcm_pkg::QCNT_W-1:0]    count_next;

    assign full      = (count_reg == ppmcm_pkg::QCNT_W'(ppmcm_pkg::QUEUE_DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_data  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            if (wr_ptr_reg == ppmcm_pkg::QPTR_W'(ppmcm_pkg::QUEUE_DEPTH - 1))
            begin
                wr_ptr_next = '0;
            end
            else
            begin
                wr_ptr_next = wr_ptr_reg + 1'b1;
            end
        end
        if (pop)
        begin
            if (rd_ptr_reg == ppmcm_pkg::QPTR_W'(ppmcm_pkg::QUEUE_DEPTH - 1))
            begin
                rd_ptr_next = '0;
            end
            else
            begin
                rd_ptr_next = rd_ptr_reg + 1'b1;
            end
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full))
        else $error("burst pushed into a full queue");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> pop_valid)
        else $error("burst popped from an empty queue");
`endif

endmodule

>>> src/ppmcm_back.sv
// ----------------------------------------------------------------------------
// ppmcm_back
// Scores the differences of one burst, clamps the winning period to the
// channel limits and divides it down to an 8-bit intensity.
// ----------------------------------------------------------------------------
module ppmcm_back (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 rec_valid,
    input  ppmcm_pkg::burst_t                    rec,
    output logic                                 rec_pop,
    input  ppmcm_pkg::limits_t                   limits,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [ppmcm_pkg::OUT_DATA_W-1:0]     m_tdata,   // period_us, intensity
    output logic [ppmcm_pkg::OUT_USER_W-1:0]     m_tuser    // color_channel
);

    localparam int PW = ppmcm_pkg::PERIOD_W;
    localparam int ND = ppmcm_pkg::NUM_DIFF;

    ppmcm_pkg::bk_state_t state_reg;
    ppmcm_pkg::bk_state_t state_next;

    logic [ND-1:0][PW-1:0]                  dx_sh_reg, dx_sh_next;
    logic [ND-1:0][PW-1:0]                  di_sh_reg, di_sh_next;
    logic [ppmcm_pkg::CHAN_W-1:0]           chan_reg, chan_next;
    logic [ppmcm_pkg::DIFF_IW-1:0]          xi_reg, xi_next;
    logic [ppmcm_pkg::DIFF_IW-1:0]          ii_reg, ii_next;
    logic [ppmcm_pkg::SCORE_W-1:0]          score_reg, score_next;
    logic [ppmcm_pkg::SCORE_W-1:0]          best_score_reg, best_score_next;
    logic [PW-1:0]                          best_reg, best_next;
    logic [PW-1:0]                          p_reg, p_next;
    logic [PW-1:0]                          den_reg, den_next;
    logic                                   den_zero_reg, den_zero_next;
    logic [ppmcm_pkg::REM_W-1:0]            rem_reg, rem_next;
    logic [ppmcm_pkg::REM_W-1:0]            dsh_reg, dsh_next;
    logic [ppmcm_pkg::VALUE_W-1:0]          q_reg, q_next;
    logic [ppmcm_pkg::DIV_CNT_W-1:0]        div_cnt_reg, div_cnt_next;
    logic                                   m_valid_reg, m_valid_next;
    logic [PW-1:0]                          out_period_reg, out_period_next;
    logic [ppmcm_pkg::VALUE_W-1:0]          out_value_reg, out_value_next;
    logic [ppmcm_pkg::CHAN_W-1:0]           out_chan_reg, out_chan_next;

    logic [PW-1:0]                          lo;
    logic [PW-1:0]                          hi;
    logic [PW-1:0]                          dx;
    logic [PW-1:0]                          di;
    logic [PW-1:0]                          err;
    logic [ppmcm_pkg::ERR_W-1:0]            err_scaled;
    logic                                   hit;
    logic [ppmcm_pkg::SCORE_W-1:0]          score_sum;
    logic                                   ii_last;
    logic                                   xi_last;
    logic [PW-1:0]                          p_low;
    logic [PW-1:0]                          p_clamped;
    logic [PW-1:0]                          num;
    logic [ppmcm_pkg::REM_W-1:0]            dividend;
    logic                                   take;
    logic                                   out_load;

    always_comb
    begin
        unique case (chan_reg)
            ppmcm_pkg::CH_RED:
            begin
                lo = limits.red_fast;
                hi = limits.red_slow;
            end
            ppmcm_pkg::CH_GREEN:
            begin
                lo = limits.green_fast;
                hi = limits.green_slow;
            end
            default:
            begin
                lo = limits.blue_fast;
                hi = limits.blue_slow;
            end
        endcase
    end

    // one pair of differences compared per cycle
    assign dx         = dx_sh_reg[0];
    assign di         = di_sh_reg[0];
    assign err        = (dx >= di) ? (dx - di) : (di - dx);
    assign err_scaled = ppmcm_pkg::ERR_W'(err) * ppmcm_pkg::ERR_W'(ppmcm_pkg::WINDOW_SCALE);
    assign hit        = (err_scaled <= ppmcm_pkg::ERR_W'(dx));
    assign score_sum  = score_reg + ppmcm_pkg::SCORE_W'(hit);
    assign ii_last    = (ii_reg == ppmcm_pkg::DIFF_IW'(ND - 1));
    assign xi_last    = (xi_reg == ppmcm_pkg::DIFF_IW'(ND - 1));

    assign p_low     = (best_reg < lo) ? lo : best_reg;
    assign p_clamped = (p_low > hi) ? hi : p_low;

    // (slow - p) * 255 as shift and subtract
    assign num      = hi - p_reg;
    assign dividend = ppmcm_pkg::REM_W'({num, ppmcm_pkg::VALUE_W'(0)})
                      - ppmcm_pkg::REM_W'(num);
    assign take     = (rem_reg >= dsh_reg);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ppmcm_pkg::BK_IDLE:
            begin
                if (rec_valid)
                begin
                    state_next = ppmcm_pkg::BK_SCORE;
                end
            end
            ppmcm_pkg::BK_SCORE:
            begin
                if (ii_last && xi_last)
                begin
                    state_next = ppmcm_pkg::BK_CLAMP;
                end
            end
            ppmcm_pkg::BK_CLAMP:
            begin
                state_next = ppmcm_pkg::BK_PREP;
            end
            ppmcm_pkg::BK_PREP:
            begin
                state_next = ppmcm_pkg::BK_DIVIDE;
            end
            ppmcm_pkg::BK_DIVIDE:
            begin
                if (div_cnt_reg == '0)
                begin
                    state_next = ppmcm_pkg::BK_DONE;
                end
            end
            ppmcm_pkg::BK_DONE:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    state_next = ppmcm_pkg::BK_IDLE;
                end
            end
            default:
            begin
                state_next = ppmcm_pkg::BK_IDLE;
            end
        endcase
    end

    // control outputs
    always_comb
    begin
        rec_pop  = (state_reg == ppmcm_pkg::BK_IDLE) && rec_valid;
        out_load = (state_reg == ppmcm_pkg::BK_DONE) && (!m_valid_reg || m_tready);
    end

    // datapath
    always_comb
    begin
        dx_sh_next      = dx_sh_reg;
        di_sh_next      = di_sh_reg;
        chan_next       = chan_reg;
        xi_next         = xi_reg;
        ii_next         = ii_reg;
        score_next      = score_reg;
        best_score_next = best_score_reg;
        best_next       = best_reg;
        p_next          = p_reg;
        den_next        = den_reg;
        den_zero_next   = den_zero_reg;
        rem_next        = rem_reg;
        dsh_next        = dsh_reg;
        q_next          = q_reg;
        div_cnt_next    = div_cnt_reg;
        out_period_next = out_period_reg;
        out_value_next  = out_value_reg;
        out_chan_next   = out_chan_reg;

        if (out_load)
        begin
            m_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_next = 1'b0;
        end
        else
        begin
            m_valid_next = m_valid_reg;
        end

        unique case (state_reg)
            ppmcm_pkg::BK_IDLE:
            begin
                if (rec_pop)
                begin
                    dx_sh_next      = rec.diff;
                    di_sh_next      = rec.diff;
                    chan_next       = rec.channel;
                    xi_next         = '0;
                    ii_next         = '0;
                    score_next      = '0;
                    best_score_next = '0;
                    best_next       = '0;
                end
            end
            ppmcm_pkg::BK_SCORE:
            begin
                di_sh_next = {di_sh_reg[0], di_sh_reg[ND-1:1]};
                if (ii_last)
                begin
                    // strictly greater keeps the lowest index on a tie
                    if (score_sum > best_score_reg)
                    begin
                        best_score_next = score_sum;
                        best_next       = dx;
                    end
                    dx_sh_next = {dx_sh_reg[0], dx_sh_reg[ND-1:1]};
                    score_next = '0;
                    ii_next    = '0;
                    xi_next    = xi_reg + 1'b1;
                end
                else
                begin
                    score_next = score_sum;
                    ii_next    = ii_reg + 1'b1;
                end
            end
            ppmcm_pkg::BK_CLAMP:
            begin
                p_next        = p_clamped;
                den_next      = hi - lo;
                den_zero_next = !(hi > lo);
            end
            ppmcm_pkg::BK_PREP:
            begin
                rem_next     = dividend;
                dsh_next     = ppmcm_pkg::REM_W'(den_reg) << (ppmcm_pkg::VALUE_W - 1);
                q_next       = '0;
                div_cnt_next = ppmcm_pkg::DIV_CNT_W'(ppmcm_pkg::DIV_STEPS - 1);
            end
            ppmcm_pkg::BK_DIVIDE:
            begin
                if (take)
                begin
                    rem_next = rem_reg - dsh_reg;
                end
                q_next       = {q_reg[ppmcm_pkg::VALUE_W-2:0], take};
                dsh_next     = dsh_reg >> 1;
                div_cnt_next = div_cnt_reg - 1'b1;
            end
            ppmcm_pkg::BK_DONE:
            begin
                if (out_load)
                begin
                    out_period_next = p_reg;
                    out_value_next  = den_zero_reg ? '0 : q_reg;
                    out_chan_next   = chan_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ppmcm_pkg::BK_IDLE;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dx_sh_reg      <= dx_sh_next;
        di_sh_reg      <= di_sh_next;
        chan_reg       <= chan_next;
        xi_reg         <= xi_next;
        ii_reg         <= ii_next;
        score_reg      <= score_next;
        best_score_reg <= best_score_next;
        best_reg       <= best_next;
        p_reg          <= p_next;
        den_reg        <= den_next;
        den_zero_reg   <= den_zero_next;
        rem_reg        <= rem_next;
        dsh_reg        <= dsh_next;
        q_reg          <= q_next;
        div_cnt_reg    <= div_cnt_next;
        out_period_reg <= out_period_next;
        out_value_reg  <= out_value_next;
        out_chan_reg   <= out_chan_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(ppmcm_pkg::OUT_DATA_W - PW - ppmcm_pkg::VALUE_W){1'b0}},
                       out_value_reg, out_period_reg};
    assign m_tuser  = out_chan_reg;

`ifndef NO_ASSERTIONS
    // every difference is within its own window, so a winner always exists
    a_winner_found: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ppmcm_pkg::BK_CLAMP) |-> (best_score_reg != '0))
        else $error("scoring finished without a winning difference");
    // restoring divider keeps the remainder below twice the shifted divisor
    a_div_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ppmcm_pkg::BK_DIVIDE) && !den_zero_reg)
        |-> ({1'b0, rem_reg} < {dsh_reg, 1'b0}))
        else $error("intensity quotient overflowed eight bits");
`endif

endmodule

>>> src/pulse_period_mode_color_map.sv
// ----------------------------------------------------------------------------
// pulse_period_mode_color_map
// Dominant pulse period and color intensity from sensor edge timestamps.
// ----------------------------------------------------------------------------
// Edge timestamps come in on the s_ side in bursts of EDGES_PER_BURST (five);
// the channel is sampled on the last edge of a burst, and each burst gives one
// result on the m_ side. Edges are taken one per cycle unless the front
// stalls. Each finished burst waits in a two-entry queue for the back end,
// which takes the burst from the queue, scores one pair of differences per
// cycle, then clamps, sets up and runs the one-bit-per-step divider for the
// eight intensity bits, and loads the output once the m_ side is free.
// The front stalls only on a last edge while the queue holds two bursts. The
// limit registers are written through cfg_we / cfg_index / cfg_data; the user
// must write them only while no burst is in flight, which the block does not
// enforce. Indexes above five are ignored.
module pulse_period_mode_color_map (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [ppmcm_pkg::IN_DATA_W-1:0]      s_tdata,   // edge_time[31:0]
    input  logic [ppmcm_pkg::IN_USER_W-1:0]      s_tuser,   // channel[1:0]
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [ppmcm_pkg::OUT_DATA_W-1:0]     m_tdata,   // period_us[30:0], intensity[38:31]
    output logic [ppmcm_pkg::OUT_USER_W-1:0]     m_tuser,   // color_channel[1:0]
    input  logic                                 cfg_we,
    input  logic [ppmcm_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [ppmcm_pkg::LIMIT_W-1:0]        cfg_data
);

    ppmcm_pkg::limits_t limits_reg;
    ppmcm_pkg::limits_t limits_next;
    ppmcm_pkg::burst_t  push_data;
    ppmcm_pkg::burst_t  pop_data;
    logic               push;
    logic               q_full;
    logic               pop;
    logic               pop_valid;

    always_comb
    begin
        limits_next = limits_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                ppmcm_pkg::REG_RED_FAST:   limits_next.red_fast   = cfg_data;
                ppmcm_pkg::REG_RED_SLOW:   limits_next.red_slow   = cfg_data;
                ppmcm_pkg::REG_GREEN_FAST: limits_next.green_fast = cfg_data;
                ppmcm_pkg::REG_GREEN_SLOW: limits_next.green_slow = cfg_data;
                ppmcm_pkg::REG_BLUE_FAST:  limits_next.blue_fast  = cfg_data;
                ppmcm_pkg::REG_BLUE_SLOW:  limits_next.blue_slow  = cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limits_reg.red_fast   <= '0;
            limits_reg.red_slow   <= ppmcm_pkg::LIMIT_W'(ppmcm_pkg::SLOW_RESET);
            limits_reg.green_fast <= '0;
            limits_reg.green_slow <= ppmcm_pkg::LIMIT_W'(ppmcm_pkg::SLOW_RESET);
            limits_reg.blue_fast  <= '0;
            limits_reg.blue_slow  <= ppmcm_pkg::LIMIT_W'(ppmcm_pkg::SLOW_RESET);
        end
        else
        begin
            limits_reg <= limits_next;
        end
    end

    ppmcm_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .q_full    (q_full),
        .push      (push),
        .push_data (push_data)
    );

    ppmcm_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (pop),
        .pop_valid (pop_valid),
        .pop_data  (pop_data)
    );

    ppmcm_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .rec_valid (pop_valid),
        .rec       (pop_data),
        .rec_pop   (pop),
        .limits    (limits_reg),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

>>> sim/pulse_period_mode_color_map_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pulse_period_mode_color_map_tb
// Self-checking bench for the pulse period color mapper.
// ----------------------------------------------------------------------------
// Sends bursts of five timestamps with random stalls on both stream sides and
// predicts the dominant period, clamp and intensity of every burst. Each
// result is checked field by field against the oldest prediction. The limit
// registers are reprogrammed between phases, including equal, inverted and
// full-range limits.
module pulse_period_mode_color_map_tb;
    import ppmcm_pkg::*;

    localparam logic [CFG_IDX_W-1:0] IDX_SPARE_A = 3'd6;
    localparam logic [CFG_IDX_W-1:0] IDX_SPARE_B = 3'd7;
    localparam logic [CHAN_W-1:0]    CH_SPARE    = 2'd3;
    localparam int                   DRAIN_CYCLES = 40;

    typedef logic [TIME_W-1:0] stamp_set_t [EDGES_PER_BURST];

    typedef struct {
        logic [PERIOD_W-1:0] period;
        logic [VALUE_W-1:0]  value;
        logic [CHAN_W-1:0]   chan;
    } color_t;

    class color_scoreboard;
        logic [LIMIT_W-1:0]  limit [6];
        logic [TIME_W-1:0]   last_stamp;
        int unsigned         edges_seen;
        logic [PERIOD_W-1:0] diffs [EDGES_PER_BURST];
        color_t              expected_colors [$];
        int unsigned         errors;
        int unsigned         bursts;
        int unsigned         checked;

        function new();
            limit = '{0, SLOW_RESET, 0, SLOW_RESET, 0, SLOW_RESET};
            errors  = 0;
            bursts  = 0;
            checked = 0;
            clear_burst();
        endfunction

        function void clear_burst();
            edges_seen = 0;
            last_stamp = '0;
            foreach (diffs[i]) diffs[i] = '0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [LIMIT_W-1:0] val);
            // indexes past the last limit register are dropped
            if (idx <= REG_BLUE_SLOW)
                limit[idx] = val;
        endfunction

        // lowest-index difference with the most neighbors in the 0.2 percent window
        function logic [PERIOD_W-1:0] dominant_diff();
            longint unsigned dx, di, err;
            int unsigned     score, best_score;
            logic [PERIOD_W-1:0] best;
            best_score = 0;
            best = '0;
            for (int x = 1; x < EDGES_PER_BURST; x++)
            begin
                dx = diffs[x];
                score = 0;
                for (int i = 1; i < EDGES_PER_BURST; i++)
                begin
                    di = diffs[i];
                    err = (dx >= di) ? dx - di : di - dx;
                    if (err * WINDOW_SCALE <= dx)
                        score++;
                end
                if (score > best_score)
                begin
                    best_score = score;
                    best = diffs[x];
                end
            end
            return best;
        endfunction

        function void take_edge(logic [TIME_W-1:0] stamp, logic [CHAN_W-1:0] chan);
            logic [TIME_W-1:0]   d;
            logic [LIMIT_W-1:0]  lo, hi;
            logic [PERIOD_W-1:0] p;
            longint unsigned     v;
            color_t              c;
            d = stamp - last_stamp;
            // negative gap: entry stays zero and the previous time is kept
            if (!d[TIME_W-1])
            begin
                if (edges_seen < EDGES_PER_BURST)
                    diffs[edges_seen] = d[PERIOD_W-1:0];
                last_stamp = stamp;
            end
            edges_seen++;
            if (edges_seen < EDGES_PER_BURST)
                return;
            if (chan > CH_BLUE)
                chan = CH_BLUE;
            lo = limit[2 * chan];
            hi = limit[2 * chan + 1];
            p = dominant_diff();
            if (p < lo)
                p = lo;
            if (p > hi)
                p = hi;
            v = 0;
            if (hi > lo)
                v = (longint'(hi - p) * 255) / longint'(hi - lo);
            c.period = p;
            c.value  = v[VALUE_W-1:0];
            c.chan   = chan;
            expected_colors.push_back(c);
            bursts++;
            clear_burst();
        endfunction

        task report(string msg);
            $display("[%0t] mismatch: %s", $realtime, msg);
            errors++;
        endtask

        task check_color(logic [OUT_DATA_W-1:0] data, logic [OUT_USER_W-1:0] user);
            color_t c;
            if (expected_colors.size() == 0)
            begin
                report($sformatf("result with nothing pending, tdata %h", data));
                return;
            end
            c = expected_colors.pop_front();
            checked++;
            if (data[PERIOD_W-1:0] !== c.period)
                report($sformatf("period_us got %0d exp %0d", data[PERIOD_W-1:0], c.period));
            if (data[PERIOD_W +: VALUE_W] !== c.value)
                report($sformatf("intensity got %0d exp %0d", data[PERIOD_W +: VALUE_W],
                                 c.value));
            if (data[OUT_DATA_W-1:PERIOD_W+VALUE_W] !== '0)
                report($sformatf("tdata padding not zero: %h", data));
            if (user !== c.chan)
                report($sformatf("color_channel got %0d exp %0d", user, c.chan));
        endtask

        function int pending();
            return expected_colors.size();
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic [IN_USER_W-1:0]  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [OUT_USER_W-1:0] m_tuser;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [LIMIT_W-1:0]    cfg_data;

    color_scoreboard sb = new();
    bit              stall_on;
    int unsigned     settings_used;
    stamp_set_t      stamps;

    pulse_period_mode_color_map dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial clk = 1'b0;
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(negedge clk)
        m_tready <= !stall_on || ($urandom_range(99) >= 23);

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                sb.take_edge(s_tdata, s_tuser);
            if (m_tvalid && m_tready)
                sb.check_color(m_tdata, m_tuser);
        end
    end

    function automatic logic [LIMIT_W-1:0] rand_limit();
        return LIMIT_W'($urandom);
    endfunction

    // called at a falling edge, returns at a falling edge
    task automatic send_burst(input stamp_set_t tt, input logic [CHAN_W-1:0] last_chan);
        for (int k = 0; k < EDGES_PER_BURST; k++)
        begin
            while (stall_on && $urandom_range(99) < 23)
            begin
                s_tvalid <= 1'b0;
                @(negedge clk);
            end
            s_tvalid <= 1'b1;
            s_tdata  <= tt[k];
            // channel only matters on the last edge
            s_tuser  <= (k == EDGES_PER_BURST - 1) ? last_chan : CHAN_W'($urandom_range(3));
            do @(posedge clk); while (!s_tready);
            @(negedge clk);
        end
    endtask

    // hold the sender until every pending burst has come out
    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending() > 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic program_limits(input logic [LIMIT_W-1:0] rf, rs, gf, gs, bf, bs);
        logic [LIMIT_W-1:0] vals [6];
        logic [LIMIT_W-1:0] junk;
        vals = '{rf, rs, gf, gs, bf, bs};
        for (int i = 0; i < 6; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= CFG_IDX_W'(i);
            cfg_data  <= vals[i];
            sb.write_reg(CFG_IDX_W'(i), vals[i]);
            @(negedge clk);
        end
        // writes to unused indexes must not disturb the limits
        junk = rand_limit();
        cfg_index <= IDX_SPARE_A;
        cfg_data  <= junk;
        sb.write_reg(IDX_SPARE_A, junk);
        @(negedge clk);
        junk = rand_limit();
        cfg_index <= IDX_SPARE_B;
        cfg_data  <= junk;
        sb.write_reg(IDX_SPARE_B, junk);
        @(negedge clk);
        cfg_we    <= 1'b0;
        cfg_index <= REG_RED_FAST;
        settings_used++;
    endtask

    task automatic random_bursts(input int count);
        stamp_set_t  tt;
        logic [31:0] period, window, jitter;
        int          kind, bad;
        for (int b = 0; b < count; b++)
        begin
            kind = $urandom_range(99);
            case ($urandom_range(9))
                0, 1, 2, 3, 4, 5: period = $urandom_range(1500, 1);
                6, 7:             period = $urandom_range(200000, 1);
                default:          period = {1'b0, 31'($urandom)};
            endcase
            tt[0] = $urandom;
            for (int k = 1; k < EDGES_PER_BURST; k++)
            begin
                window = period / WINDOW_SCALE;
                jitter = $urandom_range(window, 0);
                tt[k] = tt[k-1] + ($urandom_range(1) ? period + jitter : period - jitter);
            end
            if (kind >= 85)
            begin
                // pure noise
                foreach (tt[k]) tt[k] = $urandom;
            end
            else if (kind >= 70)
            begin
                // one edge steps backwards
                bad = $urandom_range(EDGES_PER_BURST - 1, 1);
                tt[bad] = tt[bad-1] - $urandom_range(1000000, 1);
            end
            send_burst(tt, CHAN_W'($urandom_range(3)));
        end
    endtask

    initial
    begin
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        m_tready  = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = REG_RED_FAST;
        cfg_data  = '0;
        stall_on  = 1'b1;
        settings_used = 1;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed bursts on the reset limits
        stamps = '{32'd100, 32'd200, 32'd300, 32'd400, 32'd500};
        send_burst(stamps, CH_RED);
        // second timestamp goes backwards
        stamps = '{32'd1000, 32'd500, 32'd1600, 32'd2200, 32'd2800};
        send_burst(stamps, CH_GREEN);
        // timestamp extremes, negative first gap, unused channel code
        stamps = '{32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_03E8,
                   32'h8000_07CE};
        send_burst(stamps, CH_SPARE);
        // all scores tie, lowest index wins
        stamps = '{32'd0, 32'd10, 32'd30, 32'd60, 32'd100};
        send_burst(stamps, CH_BLUE);
        // period above the slow limit, one gap on the window edge
        stamps = '{32'd5000, 32'd10000, 32'd15000, 32'd20000, 32'd25010};
        send_burst(stamps, CH_RED);
        drain();

        program_limits(rand_limit() >> 20, 31'd1000 + (rand_limit() >> 14),
                       rand_limit() >> 20, 31'd1000 + (rand_limit() >> 14),
                       rand_limit() >> 20, 31'd1000 + (rand_limit() >> 14));
        random_bursts(15);
        drain();

        program_limits('0, '1, '0, '1, '0, '1);
        random_bursts(15);
        drain();

        // equal limits
        program_limits(31'd500, 31'd500, '0, '0, '1, '1);
        random_bursts(15);
        drain();

        // fast limit above slow limit
        program_limits(31'd2000, 31'd100, '1, '0, 31'd1500, 31'd1499);
        random_bursts(15);
        drain();

        // long stretch with no idling on either side
        stall_on = 1'b0;
        program_limits(rand_limit(), rand_limit(), rand_limit(),
                       rand_limit(), rand_limit(), rand_limit());
        random_bursts(15);
        drain();
        stall_on = 1'b1;

        program_limits(31'd100, 31'd1600, 31'd1, 31'd200000, 31'd50, 31'd900);
        random_bursts(15);
        drain();

        program_limits(rand_limit(), rand_limit(), rand_limit(),
                       rand_limit(), rand_limit(), rand_limit());
        random_bursts(15);
        drain();

        $display("covered %0d bursts under %0d limit settings with random stalls",
                 sb.bursts, settings_used);
        $display("%0d results checked, %0d mismatches", sb.checked, sb.errors);
        if (sb.errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        #400000;
        $display("timeout with %0d results still pending", sb.pending());
        $display("Simulation FAILED");
        $finish;
    end

endmodule

>>> pulse_period_mode_color_map.f
src/ppmcm_pkg.sv
src/ppmcm_front.sv
src/ppmcm_queue.sv
src/ppmcm_back.sv
src/pulse_period_mode_color_map.sv
sim/pulse_period_mode_color_map_tb.sv
